// File: src/osc_pkg.sv
// osc_pkg: shared widths, register indexes, waveform codes and the quarter-sine
// table generator for the oscillator
// no dependencies
package osc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned WAVE_W     = 2;
  localparam int unsigned RATE_W     = 18;
  localparam int unsigned NOTE_W     = 24;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SINE_W     = 16;
  localparam int unsigned ENV_W      = 16;
  localparam int unsigned Q15_SH     = 15;

  // envelope divider: quotient always fits in 16 bits
  localparam int unsigned QUOT_W = 16;
  localparam int unsigned DEN_W  = 21;
  localparam int unsigned NUM_W  = 43;
  localparam int unsigned DCNT_W = $clog2(QUOT_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENVELOPE_ON = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_LENGTH = 3'd5;

  localparam logic [WAVE_W-1:0] WAVE_SINE     = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 2'd2;
  localparam logic [WAVE_W-1:0] WAVE_SAW      = 2'd3;

  localparam logic [RATE_W-1:0] RATE_RESET  = 18'd48000;
  localparam logic [NOTE_W-1:0] NOTE_RESET  = 24'd48000;
  localparam logic [ENV_W-1:0]  SUSTAIN_Q15 = 16'd26214;

  // pi in Q2.30 and the taylor divisors (2m)(2m+1)
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [7:0]  TAYLOR_DIV [1:7] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156,
                                               8'd210};

  // quarter-wave entry k of a table with 2^bits steps, evaluated at elaboration
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k,
                                                   input int unsigned bits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    x    = (PI_Q30 * 64'(k)) >> (bits + 1);
    term = x;
    sum  = longint'(x);
    for (int m = 1; m <= 7; m++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[m];
      if (m % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = ((64'(sum) << 15) + 64'd536870912) >> 30;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return SINE_W'(v);
  endfunction

endpackage

// File: src/osc_sine_rom.sv
// osc_sine_rom: quarter-wave sine table with registered read
// depends on osc_pkg (sine_entry)
module osc_sine_rom #(
  parameter int TBL_BITS = 8
) (
  input  logic                       clk,
  input  logic [TBL_BITS:0]          addr,
  output logic [osc_pkg::SINE_W-1:0] data
);

  localparam int TBL_LEN = 1 << TBL_BITS;

  logic [osc_pkg::SINE_W-1:0] tbl [TBL_LEN+1];
  logic [osc_pkg::SINE_W-1:0] data_r;

  for (genvar g = 0; g <= TBL_LEN; g++) begin : g_tbl
    assign tbl[g] = osc_pkg::sine_entry(g, TBL_BITS);
  end

  always_ff @(posedge clk) begin
    data_r <= tbl[addr];
  end

  assign data = data_r;

endmodule

// File: src/osc_div.sv
// osc_div: restoring divider, one quotient bit per cycle
// depends on osc_pkg; caller guarantees num < den * 2^QUOT_W
module osc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [osc_pkg::NUM_W-1:0]  num,
  input  logic [osc_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [osc_pkg::QUOT_W-1:0] quot
);

  localparam int DW = osc_pkg::DEN_W;
  localparam int QW = osc_pkg::QUOT_W;

  logic [DW-1:0]              rem_r;
  logic [DW-1:0]              den_r;
  logic [QW-1:0]              low_r;
  logic [QW-1:0]              quot_r;
  logic [osc_pkg::DCNT_W-1:0] cnt_r;
  logic                       done_r;
  logic [DW:0]                trial;
  logic [DW:0]                diff;
  logic                       ge;

  assign trial = {rem_r, low_r[QW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // upper part is already below the divisor
        rem_r <= DW'(num[osc_pkg::NUM_W-1:QW]);
        low_r <= num[QW-1:0];
        den_r <= den;
        cnt_r <= osc_pkg::DCNT_W'(QW);
      end else if (cnt_r != '0) begin
        rem_r  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low_r  <= {low_r[QW-2:0], 1'b0};
        quot_r <= {quot_r[QW-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == osc_pkg::DCNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: src/waveform_oscillator_with_adsr.sv
// waveform_oscillator_with_adsr: top level, sequencer with one shared multiplier
// depends on osc_pkg, osc_sine_rom, osc_div
//
// Each input transfer is one sample tick; it yields one output transfer with the
// next sample of the note (sine, square, triangle or sawtooth from a 32-bit phase
// accumulator, optionally scaled by an ADSR envelope). A tick with no note
// sounding goes straight to the output state; otherwise it works out the wave
// from the phase and the amplitude, and with the envelope on it then scales it
// by the envelope level: the sustain level, zero past the end of the note, or
// in the attack, decay or release a quotient from the 16-step envelope divider.
// A tick also waits in its final state while an earlier result still sits
// unaccepted in the output register. The block takes one tick at a time; a
// finished sample sits in the output register while the next tick is accepted.
// Configuration is taken only between ticks: cfg_ready is low during a tick.
module waveform_oscillator_with_adsr #(
  parameter int SINE_TABLE_BITS = 8,
  parameter int INDEX_BITS      = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [osc_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                 out_last,
  output logic                                 out_active,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [osc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [osc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int IW     = INDEX_BITS;
  localparam int TB     = SINE_TABLE_BITS;
  localparam int NW     = osc_pkg::NOTE_W;
  localparam int RW     = osc_pkg::RATE_W;
  localparam int AW     = osc_pkg::AMP_W;
  localparam int SW     = osc_pkg::STEP_W;
  localparam int DW     = osc_pkg::DEN_W;
  localparam int PW     = AW + SW;
  localparam int EW     = ((IW + 5) > 29 ? (IW + 5) : 29) + 1;
  localparam int CW     = ((IW + 1) > NW) ? (IW + 1) : NW;
  localparam int QS     = osc_pkg::Q15_SH;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROM  = 4'd1;
  localparam logic [3:0] S_WMUL = 4'd2;
  localparam logic [3:0] S_WAVE = 4'd3;
  localparam logic [3:0] S_ENV0 = 4'd4;
  localparam logic [3:0] S_ATT  = 4'd5;
  localparam logic [3:0] S_DEC  = 4'd6;
  localparam logic [3:0] S_SUS0 = 4'd7;
  localparam logic [3:0] S_SUS  = 4'd8;
  localparam logic [3:0] S_REL  = 4'd9;
  localparam logic [3:0] S_DIVW = 4'd10;
  localparam logic [3:0] S_EMUL = 4'd11;
  localparam logic [3:0] S_EFIN = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  localparam logic [1:0] SH_SINE = 2'd0;
  localparam logic [1:0] SH_TRI  = 2'd1;
  localparam logic [1:0] SH_SAW  = 2'd2;

  // configuration
  logic [SW-1:0]                  phase_step_r;
  logic [AW-1:0]                  amplitude_r;
  logic [osc_pkg::WAVE_W-1:0]     waveform_r;
  logic                           envelope_on_r;
  logic [RW-1:0]                  sample_rate_r;
  logic [NW-1:0]                  note_length_r;

  // note state
  logic [3:0]                     state_r;
  logic [IW-1:0]                  idx_r;
  logic [SW-1:0]                  phase_r;
  logic                           playing_r;

  // working registers
  logic [SW-1:0]                  m_r;
  logic                           neg_r;
  logic [1:0]                     sh_r;
  logic                           last_r;
  logic [PW-1:0]                  prod_r;
  logic [AW-1:0]                  mag_r;
  logic [EW-1:0]                  t20i_r;
  logic                           short_r;
  logic [DW-1:0]                  r5_r;
  logic [DW-1:0]                  r6_r;
  logic [EW-1:0]                  sus_lhs_r;
  logic [EW-1:0]                  sus_rhs_r;
  logic [osc_pkg::ENV_W-1:0]      env_r;
  logic [osc_pkg::NUM_W-1:0]      div_num_r;
  logic [DW-1:0]                  div_den_r;
  logic                           div_go_r;

  logic                           out_valid_r;
  logic [osc_pkg::SAMPLE_W-1:0]   out_sample_r;
  logic                           out_last_r;
  logic                           out_active_r;

  logic [NW-1:0]                  n_eff;
  logic [RW-1:0]                  r_eff;
  logic [TB:0]                    rom_addr;
  logic [osc_pkg::SINE_W-1:0]     rom_q;
  logic [SW-1:0]                  m_nxt;
  logic                           neg_nxt;
  logic [1:0]                     sh_nxt;
  logic [AW-1:0]                  mul_a;
  logic [SW-1:0]                  mul_b;
  logic [PW-1:0]                  mul_p;
  logic [AW-1:0]                  wave_mag;
  logic [NW-1:0]                  rel_diff;
  logic [osc_pkg::SAMPLE_W-1:0]   mag_ext;
  logic [osc_pkg::SAMPLE_W-1:0]   sample_nxt;
  logic                           div_done;
  logic [osc_pkg::QUOT_W-1:0]     div_quot;
  logic                           out_free;

  assign n_eff    = (note_length_r == '0) ? NW'(1) : note_length_r;
  assign r_eff    = (sample_rate_r == '0) ? RW'(1) : sample_rate_r;
  assign rel_diff = n_eff - NW'(idx_r);
  assign out_free = !out_valid_r || out_ready;

  // quadrants 1 and 3 read the table mirrored
  assign rom_addr = phase_r[30] ? ({1'b1, {TB{1'b0}}} - {1'b0, phase_r[29 -: TB]})
                                : {1'b0, phase_r[29 -: TB]};

  osc_sine_rom #(
    .TBL_BITS (TB)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  osc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // multiplier operand and sign for the wave, from the phase
  always_comb begin
    m_nxt   = phase_r;
    neg_nxt = phase_r[31];
    sh_nxt  = SH_SINE;
    case (waveform_r)
      osc_pkg::WAVE_TRIANGLE: begin
        sh_nxt = SH_TRI;
        case (phase_r[31:30])
          2'd0: begin
            m_nxt   = phase_r;
            neg_nxt = 1'b0;
          end
          2'd1: begin
            m_nxt   = 32'h8000_0000 - phase_r;
            neg_nxt = 1'b0;
          end
          2'd2: begin
            m_nxt   = {1'b0, phase_r[30:0]};
            neg_nxt = 1'b1;
          end
          default: begin
            m_nxt   = '0 - phase_r;
            neg_nxt = 1'b1;
          end
        endcase
      end
      osc_pkg::WAVE_SAW: begin
        sh_nxt  = SH_SAW;
        m_nxt   = phase_r[31] ? ('0 - phase_r) : phase_r;
        neg_nxt = phase_r[31];
      end
      default: begin
        m_nxt   = phase_r;
        neg_nxt = phase_r[31];
      end
    endcase
  end

  // shared multiplier: amplitude times wave operand, then magnitude times envelope
  always_comb begin
    if (state_r == S_EMUL) begin
      mul_a = mag_r;
      mul_b = SW'(env_r);
    end else begin
      mul_a = amplitude_r;
      mul_b = (waveform_r == osc_pkg::WAVE_SINE) ? SW'(rom_q) : m_r;
    end
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  always_comb begin
    case (sh_r)
      SH_TRI:  wave_mag = prod_r[30 +: AW];
      SH_SAW:  wave_mag = prod_r[31 +: AW];
      default: wave_mag = prod_r[QS +: AW];
    endcase
  end

  assign mag_ext    = osc_pkg::SAMPLE_W'(mag_r);
  assign sample_nxt = neg_r ? ('0 - mag_ext) : mag_ext;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r  <= '0;
      amplitude_r   <= '0;
      waveform_r    <= osc_pkg::WAVE_SINE;
      envelope_on_r <= 1'b0;
      sample_rate_r <= osc_pkg::RATE_RESET;
      note_length_r <= osc_pkg::NOTE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        osc_pkg::REG_PHASE_STEP:  phase_step_r  <= cfg_data[SW-1:0];
        osc_pkg::REG_AMPLITUDE:   amplitude_r   <= cfg_data[AW-1:0];
        osc_pkg::REG_WAVEFORM:    waveform_r    <= cfg_data[osc_pkg::WAVE_W-1:0];
        osc_pkg::REG_ENVELOPE_ON: envelope_on_r <= cfg_data[0];
        osc_pkg::REG_SAMPLE_RATE: sample_rate_r <= cfg_data[RW-1:0];
        osc_pkg::REG_NOTE_LENGTH: note_length_r <= cfg_data[NW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      phase_r     <= '0;
      playing_r   <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // the final state reloads the result register itself
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_restart) begin
              playing_r <= 1'b1;
              idx_r     <= '0;
              phase_r   <= '0;
            end
            if (in_restart || playing_r) begin
              state_r <= S_ROM;
            end else begin
              mag_r   <= '0;
              neg_r   <= 1'b0;
              last_r  <= 1'b0;
              state_r <= S_DONE;
            end
          end
        end
        S_ROM: begin
          m_r     <= m_nxt;
          neg_r   <= neg_nxt;
          sh_r    <= sh_nxt;
          last_r  <= (CW'(idx_r) + CW'(1)) >= CW'(n_eff);
          state_r <= S_WMUL;
        end
        S_WMUL: begin
          prod_r  <= mul_p;
          state_r <= S_WAVE;
        end
        S_WAVE: begin
          mag_r   <= (waveform_r == osc_pkg::WAVE_SQUARE) ? amplitude_r : wave_mag;
          state_r <= envelope_on_r ? S_ENV0 : S_DONE;
        end
        S_ENV0: begin
          t20i_r  <= (EW'(idx_r) << 4) + (EW'(idx_r) << 2);
          short_r <= n_eff < NW'(r_eff);
          r5_r    <= (DW'(r_eff) << 2) + DW'(r_eff);
          r6_r    <= (DW'(r_eff) << 2) + (DW'(r_eff) << 1);
          state_r <= S_ATT;
        end
        S_ATT: begin
          // attack
          if (t20i_r < EW'(r_eff)) begin
            div_num_r <= osc_pkg::NUM_W'({t20i_r, {QS{1'b0}}});
            div_den_r <= DW'(r_eff);
            div_go_r  <= 1'b1;
            state_r   <= S_DIVW;
          end else begin
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          // decay toward sustain level
          if ((t20i_r >> 1) < EW'(r_eff)) begin
            div_num_r <= osc_pkg::NUM_W'({r6_r - t20i_r[DW-1:0], {QS{1'b0}}});
            div_den_r <= r5_r;
            div_go_r  <= 1'b1;
            state_r   <= S_DIVW;
          end else begin
            state_r <= S_SUS0;
          end
        end
        S_SUS0: begin
          sus_lhs_r <= short_r ? (t20i_r + EW'(r_eff))
                               : ((EW'(idx_r) << 1) + EW'(r_eff));
          sus_rhs_r <= short_r ? ((EW'(n_eff) << 4) + (EW'(n_eff) << 2))
                               : (EW'(n_eff) << 1);
          state_r   <= S_SUS;
        end
        S_SUS: begin
          if (sus_lhs_r < sus_rhs_r) begin
            env_r   <= osc_pkg::SUSTAIN_Q15;
            state_r <= S_EMUL;
          end else begin
            state_r <= S_REL;
          end
        end
        S_REL: begin
          // release, or silence past the end of the note
          if (EW'(idx_r) < EW'(n_eff)) begin
            div_num_r <= short_r ? osc_pkg::NUM_W'({rel_diff, 19'd0})
                                 : osc_pkg::NUM_W'({rel_diff, 18'd0});
            div_den_r <= short_r ? DW'(r_eff) : r5_r;
            div_go_r  <= 1'b1;
            state_r   <= S_DIVW;
          end else begin
            env_r   <= '0;
            state_r <= S_EMUL;
          end
        end
        S_DIVW: begin
          div_go_r <= 1'b0;
          if (div_done) begin
            env_r   <= div_quot;
            state_r <= S_EMUL;
          end
        end
        S_EMUL: begin
          prod_r  <= mul_p;
          state_r <= S_EFIN;
        end
        S_EFIN: begin
          mag_r   <= prod_r[QS +: AW];
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= sample_nxt;
            out_last_r   <= last_r;
            out_active_r <= playing_r;
            if (playing_r) begin
              idx_r   <= idx_r + 1'b1;
              phase_r <= phase_r + phase_step_r;
              if (last_r) begin
                playing_r <= 1'b0;
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;
  assign out_active = out_active_r;

endmodule

// File: src/osc_checker.sv
// osc_checker: port-level checks for the oscillator, attached by bind
// depends on osc_pkg and waveform_oscillator_with_adsr
module osc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [osc_pkg::SAMPLE_W-1:0] out_sample,
  input logic                                out_last,
  input logic                                out_active
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last)
                                && $stable(out_active))
    else $error("result changed while stalled");

  // a tick transfer starts the sequencer, so the next cycle is busy
  a_busy_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a tick transfer");

  // silent ticks carry a zero sample
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_active |-> out_sample == '0 && !out_last)
    else $error("sample or last set with no note");

  a_last_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_active)
    else $error("last without an active note");

endmodule

bind waveform_oscillator_with_adsr osc_checker u_osc_checker (.*);
